/* rtl/qmn_pkg.sv */
// constants and types shared by the quaternion product normaliser
`default_nettype none
package qmn_pkg;

    localparam int COMP_BITS  = 16;
    localparam int FRAC_BITS  = COMP_BITS - 2;
    localparam int PROD_BITS  = 2 * COMP_BITS;
    localparam int SUM_BITS   = PROD_BITS + 2;
    localparam int MAG_BITS   = PROD_BITS + 1;
    localparam int LEN_BITS   = $clog2(MAG_BITS + 1);
    localparam int NORM_BITS  = 30;
    localparam int SQ_BITS    = 2 * NORM_BITS;
    localparam int SSUM_BITS  = SQ_BITS + 2;
    localparam int ROOT_STEPS = NORM_BITS + 1;
    localparam int ROOT_BITS  = NORM_BITS + 1;
    localparam int QUOT_BITS  = FRAC_BITS + 1;
    localparam int REM_BITS   = ROOT_BITS + QUOT_BITS - 1;
    localparam int N_TERMS    = 16;

    typedef logic [COMP_BITS-1:0] comp_t;
    typedef logic [NORM_BITS-1:0] norm_t;
    typedef logic [QUOT_BITS-1:0] quot_t;

    localparam comp_t W_ONE = comp_t'(1) << FRAC_BITS;
    localparam quot_t Q_ONE = quot_t'(1) << FRAC_BITS;

endpackage
`default_nettype wire

/* rtl/quaternion_multiply_normalize_core.sv */
// hamilton product of two q2.14 quaternions, scaled to unit length
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid, in_stall, left_*, right_*       | into core
//  out      | out_valid, out_stall, prod_*, zero_length | out of core
//
// one transfer per cycle sustained while the output is not held
// most of the pipeline is the bit-serial square root (31 stages) and the four
// restoring dividers (15 stages each), one result bit per stage
// all stages advance together; a held output stalls the whole pipeline
// reset clears only the valid bits; payload registers are not reset
`default_nettype none
module quaternion_multiply_normalize_core
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic signed [qmn_pkg::COMP_BITS-1:0] left_x,
    input  wire logic signed [qmn_pkg::COMP_BITS-1:0] left_y,
    input  wire logic signed [qmn_pkg::COMP_BITS-1:0] left_z,
    input  wire logic signed [qmn_pkg::COMP_BITS-1:0] left_w,
    input  wire logic signed [qmn_pkg::COMP_BITS-1:0] right_x,
    input  wire logic signed [qmn_pkg::COMP_BITS-1:0] right_y,
    input  wire logic signed [qmn_pkg::COMP_BITS-1:0] right_z,
    input  wire logic signed [qmn_pkg::COMP_BITS-1:0] right_w,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [qmn_pkg::COMP_BITS-1:0] prod_x,
    output logic signed [qmn_pkg::COMP_BITS-1:0] prod_y,
    output logic signed [qmn_pkg::COMP_BITS-1:0] prod_z,
    output logic signed [qmn_pkg::COMP_BITS-1:0] prod_w,
    output logic                       zero_length
);
    import qmn_pkg::*;

    // global advance: everything moves unless a finished result is held
    logic adv;

    // stage 1: the sixteen partial products
    logic                        v1_reg;
    logic signed [PROD_BITS-1:0] prod_reg [0:N_TERMS-1];

    // stage 2: the four exact product components
    logic                        v2_reg;
    logic signed [SUM_BITS-1:0]  p_reg [0:3];

    // stage 3: sign and magnitude, common bit mask
    logic                        v3_reg;
    logic [MAG_BITS-1:0]         mag3_reg [0:3];
    logic [3:0]                  neg3_reg;
    logic                        zero3_reg;
    logic [MAG_BITS-1:0]         or3_reg;

    // stage 4: bit length of the largest magnitude
    logic                        v4_reg;
    logic [MAG_BITS-1:0]         mag4_reg [0:3];
    logic [3:0]                  neg4_reg;
    logic                        zero4_reg;
    logic [LEN_BITS-1:0]         len4_reg;
    logic [LEN_BITS-1:0]         len_next;

    // stage 5: block-normalised magnitudes
    logic                        v5_reg;
    norm_t                       q5_reg [0:3];
    logic [3:0]                  neg5_reg;
    logic                        zero5_reg;

    // stage 6: squares
    logic                        v6_reg;
    logic [SQ_BITS-1:0]          sq6_reg [0:3];
    norm_t                       q6_reg [0:3];
    logic [3:0]                  neg6_reg;
    logic                        zero6_reg;

    // square root pipeline, entry 0 holds the sum of squares
    logic                        rt_v_reg    [0:ROOT_STEPS];
    logic [SSUM_BITS-1:0]        rt_s_reg    [0:ROOT_STEPS];
    logic [SSUM_BITS-1:0]        rt_res_reg  [0:ROOT_STEPS];
    norm_t                       rt_q_reg    [0:ROOT_STEPS][0:3];
    logic [3:0]                  rt_neg_reg  [0:ROOT_STEPS];
    logic                        rt_zero_reg [0:ROOT_STEPS];
    logic [SSUM_BITS-1:0]        rt_s_next   [1:ROOT_STEPS];
    logic [SSUM_BITS-1:0]        rt_res_next [1:ROOT_STEPS];

    // divider pipeline, entry 0 holds the rounded numerators
    logic                        dv_v_reg    [0:QUOT_BITS];
    logic [REM_BITS-1:0]         dv_rem_reg  [0:QUOT_BITS][0:3];
    quot_t                       dv_quo_reg  [0:QUOT_BITS][0:3];
    logic [ROOT_BITS-1:0]        dv_r_reg    [0:QUOT_BITS];
    logic [3:0]                  dv_neg_reg  [0:QUOT_BITS];
    logic                        dv_zero_reg [0:QUOT_BITS];
    logic [REM_BITS-1:0]         dv_rem_next [1:QUOT_BITS][0:3];
    quot_t                       dv_quo_next [1:QUOT_BITS][0:3];

    // output register
    logic                        out_valid_reg;
    comp_t                       out_c_reg [0:3];
    logic                        out_zero_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign adv      = !in_stall;

    // priority search for the top set bit
    always_comb
    begin
        len_next = '0;
        for (int b = 0; b < MAG_BITS; b++)
        begin
            if (or3_reg[b])
                len_next = LEN_BITS'(b + 1);
        end
    end

    // one root bit per stage: bit weight 4^(NORM_BITS - k)
    always_comb
    begin
        logic [SSUM_BITS-1:0] bitw;
        logic [SSUM_BITS-1:0] trial;
        for (int k = 0; k < ROOT_STEPS; k++)
        begin
            bitw  = SSUM_BITS'(1) << (2 * (NORM_BITS - k));
            trial = rt_res_reg[k] + bitw;
            if (rt_s_reg[k] >= trial)
            begin
                rt_s_next[k+1]   = rt_s_reg[k] - trial;
                rt_res_next[k+1] = (rt_res_reg[k] >> 1) + bitw;
            end
            else
            begin
                rt_s_next[k+1]   = rt_s_reg[k];
                rt_res_next[k+1] = rt_res_reg[k] >> 1;
            end
        end
    end

    // one quotient bit per stage, restoring division
    always_comb
    begin
        logic [REM_BITS-1:0] dsh;
        for (int j = 0; j < QUOT_BITS; j++)
        begin
            dsh = REM_BITS'(dv_r_reg[j]) << (QUOT_BITS - 1 - j);
            for (int i = 0; i < 4; i++)
            begin
                if (dv_rem_reg[j][i] >= dsh)
                begin
                    dv_rem_next[j+1][i] = dv_rem_reg[j][i] - dsh;
                    dv_quo_next[j+1][i] = dv_quo_reg[j][i]
                                          | (quot_t'(1) << (QUOT_BITS - 1 - j));
                end
                else
                begin
                    dv_rem_next[j+1][i] = dv_rem_reg[j][i];
                    dv_quo_next[j+1][i] = dv_quo_reg[j][i];
                end
            end
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            for (int k = 0; k <= ROOT_STEPS; k++)
                rt_v_reg[k] <= 1'b0;
            for (int j = 0; j <= QUOT_BITS; j++)
                dv_v_reg[j] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg      <= in_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            rt_v_reg[0] <= v6_reg;
            for (int k = 0; k < ROOT_STEPS; k++)
                rt_v_reg[k+1] <= rt_v_reg[k];
            dv_v_reg[0] <= rt_v_reg[ROOT_STEPS];
            for (int j = 0; j < QUOT_BITS; j++)
                dv_v_reg[j+1] <= dv_v_reg[j];
            out_valid_reg <= dv_v_reg[QUOT_BITS];
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // x terms
            prod_reg[0]  <= left_w * right_x;
            prod_reg[1]  <= left_x * right_w;
            prod_reg[2]  <= left_y * right_z;
            prod_reg[3]  <= left_z * right_y;
            // y terms
            prod_reg[4]  <= left_w * right_y;
            prod_reg[5]  <= left_x * right_z;
            prod_reg[6]  <= left_y * right_w;
            prod_reg[7]  <= left_z * right_x;
            // z terms
            prod_reg[8]  <= left_w * right_z;
            prod_reg[9]  <= left_x * right_y;
            prod_reg[10] <= left_y * right_x;
            prod_reg[11] <= left_z * right_w;
            // w terms
            prod_reg[12] <= left_w * right_w;
            prod_reg[13] <= left_x * right_x;
            prod_reg[14] <= left_y * right_y;
            prod_reg[15] <= left_z * right_z;

            p_reg[0] <= SUM_BITS'(prod_reg[0]) + SUM_BITS'(prod_reg[1])
                      + SUM_BITS'(prod_reg[2]) - SUM_BITS'(prod_reg[3]);
            p_reg[1] <= SUM_BITS'(prod_reg[4]) - SUM_BITS'(prod_reg[5])
                      + SUM_BITS'(prod_reg[6]) + SUM_BITS'(prod_reg[7]);
            p_reg[2] <= SUM_BITS'(prod_reg[8]) + SUM_BITS'(prod_reg[9])
                      - SUM_BITS'(prod_reg[10]) + SUM_BITS'(prod_reg[11]);
            p_reg[3] <= SUM_BITS'(prod_reg[12]) - SUM_BITS'(prod_reg[13])
                      - SUM_BITS'(prod_reg[14]) - SUM_BITS'(prod_reg[15]);

            for (int i = 0; i < 4; i++)
            begin
                neg3_reg[i] <= p_reg[i][SUM_BITS-1];
                mag3_reg[i] <= p_reg[i][SUM_BITS-1] ? MAG_BITS'(-p_reg[i])
                                                    : MAG_BITS'(p_reg[i]);
            end
            zero3_reg <= (p_reg[0] == '0) && (p_reg[1] == '0)
                      && (p_reg[2] == '0) && (p_reg[3] == '0);
            // or of the magnitudes shares its top bit with the largest one
            or3_reg   <= (p_reg[0][SUM_BITS-1] ? MAG_BITS'(-p_reg[0]) : MAG_BITS'(p_reg[0]))
                       | (p_reg[1][SUM_BITS-1] ? MAG_BITS'(-p_reg[1]) : MAG_BITS'(p_reg[1]))
                       | (p_reg[2][SUM_BITS-1] ? MAG_BITS'(-p_reg[2]) : MAG_BITS'(p_reg[2]))
                       | (p_reg[3][SUM_BITS-1] ? MAG_BITS'(-p_reg[3]) : MAG_BITS'(p_reg[3]));

            mag4_reg  <= mag3_reg;
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
            len4_reg  <= len_next;

            for (int i = 0; i < 4; i++)
            begin
                if (len4_reg > LEN_BITS'(NORM_BITS))
                    q5_reg[i] <= NORM_BITS'(mag4_reg[i]
                                 >> (len4_reg - LEN_BITS'(NORM_BITS)));
                else
                    q5_reg[i] <= NORM_BITS'(mag4_reg[i]
                                 << (LEN_BITS'(NORM_BITS) - len4_reg));
            end
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;

            for (int i = 0; i < 4; i++)
                sq6_reg[i] <= SQ_BITS'(q5_reg[i]) * SQ_BITS'(q5_reg[i]);
            q6_reg    <= q5_reg;
            neg6_reg  <= neg5_reg;
            zero6_reg <= zero5_reg;

            rt_s_reg[0]    <= SSUM_BITS'(sq6_reg[0]) + SSUM_BITS'(sq6_reg[1])
                            + SSUM_BITS'(sq6_reg[2]) + SSUM_BITS'(sq6_reg[3]);
            rt_res_reg[0]  <= '0;
            rt_q_reg[0]    <= q6_reg;
            rt_neg_reg[0]  <= neg6_reg;
            rt_zero_reg[0] <= zero6_reg;
            for (int k = 0; k < ROOT_STEPS; k++)
            begin
                rt_s_reg[k+1]    <= rt_s_next[k+1];
                rt_res_reg[k+1]  <= rt_res_next[k+1];
                rt_q_reg[k+1]    <= rt_q_reg[k];
                rt_neg_reg[k+1]  <= rt_neg_reg[k];
                rt_zero_reg[k+1] <= rt_zero_reg[k];
            end

            // numerator with half the divisor added for rounding
            for (int i = 0; i < 4; i++)
            begin
                dv_rem_reg[0][i] <= (REM_BITS'(rt_q_reg[ROOT_STEPS][i]) << FRAC_BITS)
                                  + REM_BITS'(rt_res_reg[ROOT_STEPS][ROOT_BITS-1:1]);
                dv_quo_reg[0][i] <= '0;
            end
            dv_r_reg[0]    <= rt_res_reg[ROOT_STEPS][ROOT_BITS-1:0];
            dv_neg_reg[0]  <= rt_neg_reg[ROOT_STEPS];
            dv_zero_reg[0] <= rt_zero_reg[ROOT_STEPS];
            for (int j = 0; j < QUOT_BITS; j++)
            begin
                dv_rem_reg[j+1]  <= dv_rem_next[j+1];
                dv_quo_reg[j+1]  <= dv_quo_next[j+1];
                dv_r_reg[j+1]    <= dv_r_reg[j];
                dv_neg_reg[j+1]  <= dv_neg_reg[j];
                dv_zero_reg[j+1] <= dv_zero_reg[j];
            end

            // apply sign, identity on a zero product
            for (int i = 0; i < 4; i++)
            begin
                if (dv_zero_reg[QUOT_BITS])
                    out_c_reg[i] <= (i == 3) ? W_ONE : '0;
                else if (dv_neg_reg[QUOT_BITS][i])
                    out_c_reg[i] <= -COMP_BITS'(dv_quo_reg[QUOT_BITS][i]);
                else
                    out_c_reg[i] <= COMP_BITS'(dv_quo_reg[QUOT_BITS][i]);
            end
            out_zero_reg <= dv_zero_reg[QUOT_BITS];
        end
    end

    assign out_valid   = out_valid_reg;
    assign prod_x      = out_c_reg[0];
    assign prod_y      = out_c_reg[1];
    assign prod_z      = out_c_reg[2];
    assign prod_w      = out_c_reg[3];
    assign zero_length = out_zero_reg;

`ifndef SYNTHESIS
    // an accepted transfer lands in the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v1_reg)
        else $error("accepted transfer lost at pipeline entry");

    // normalised sum of squares gives a root in [2^29, 2^31)
    a_root: assert property (@(posedge clk) disable iff (!rst_n)
        rt_v_reg[ROOT_STEPS] && !rt_zero_reg[ROOT_STEPS]
        |-> rt_res_reg[ROOT_STEPS] >= (SSUM_BITS'(1) << (NORM_BITS - 1))
         && rt_res_reg[ROOT_STEPS] <  (SSUM_BITS'(1) << NORM_BITS + 1))
        else $error("square root out of expected range");

    // unit length bounds every quotient by one
    a_quot: assert property (@(posedge clk) disable iff (!rst_n)
        dv_v_reg[QUOT_BITS] && !dv_zero_reg[QUOT_BITS]
        |-> dv_quo_reg[QUOT_BITS][0] <= Q_ONE && dv_quo_reg[QUOT_BITS][1] <= Q_ONE
         && dv_quo_reg[QUOT_BITS][2] <= Q_ONE && dv_quo_reg[QUOT_BITS][3] <= Q_ONE)
        else $error("normalised component exceeds one");

    // zero product gives the identity
    a_ident: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_length
        |-> prod_x == '0 && prod_y == '0 && prod_z == '0 && prod_w == W_ONE)
        else $error("zero product did not give identity");
`endif

endmodule
`default_nettype wire
